>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every check is sampled on the rising clock edge and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property.
`define SDFR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define SDFR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SDFR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sdfr_pkg.sv
package sdfr_pkg;

   // operation codes
   localparam logic [1:0] OP_RECEIVE = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // parser phase codes as reported on the result channel
   localparam logic [2:0] PHASE_IDLE   = 3'd0;
   localparam logic [2:0] PHASE_SYNC2  = 3'd1;
   localparam logic [2:0] PHASE_LENGTH = 3'd2;
   localparam logic [2:0] PHASE_HEAD   = 3'd3;
   localparam logic [2:0] PHASE_DATA   = 3'd4;
   localparam logic [2:0] PHASE_END    = 3'd5;
   localparam logic [2:0] PHASE_HOLD   = 3'd6;

   // framing bytes
   localparam logic [7:0] SYNC_A = 8'h55;
   localparam logic [7:0] SYNC_B = 8'hAA;
   localparam logic [7:0] DELIM  = 8'h7E;
   localparam logic [1:0] PAIR   = 2'd2;

   // parser outcome for one item
   typedef struct packed {
      logic [2:0] phase;
      logic       ready;
      logic [9:0] length;
      logic       aborted;
   } result_type;

endpackage

>>> rtl/sdfr_store.sv
module sdfr_store #(
   parameter int BUFFER_DEPTH = 1024,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sdfr_parser.sv
`include "assert_macros.svh"

module sdfr_parser #(
   parameter int BUFFER_DEPTH = 1024,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           operation,
   input  logic [7:0]           rx_byte,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [7:0]           wr_data,
   output sdfr_pkg::result_type result
);

   import sdfr_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE   = PHASE_IDLE,
      PH_SYNC2  = PHASE_SYNC2,
      PH_LENGTH = PHASE_LENGTH,
      PH_HEAD   = PHASE_HEAD,
      PH_DATA   = PHASE_DATA,
      PH_END    = PHASE_END,
      PH_HOLD   = PHASE_HOLD
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [1:0]    sub_ff, sub_in;
   logic [AW-1:0] count_ff, count_in;
   logic [AW:0]   count_plus;
   logic [1:0]    sub_plus;
   logic          ready;
   logic          abort;

   assign count_plus = {1'b0, count_ff} + {{AW{1'b0}}, 1'b1};
   assign sub_plus   = sub_ff + 2'd1;

   // next parser state for the accepted item
   always_comb begin
      phase_in = phase_ff;
      sub_in   = sub_ff;
      count_in = count_ff;
      ready    = 1'b0;
      abort    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = count_ff;
      wr_data  = rx_byte;
      if (accept) begin
         unique case (operation)
            OP_RECEIVE: begin
               if (phase_ff != PH_HOLD) begin
                  // count stays below depth, so every byte lands in the store
                  wr_en    = 1'b1;
                  count_in = count_plus[AW-1:0];
                  unique case (phase_ff)
                     PH_IDLE: begin
                        if (rx_byte == SYNC_A) begin
                           phase_in = PH_SYNC2;
                        end else begin
                           phase_in = PH_IDLE;
                           sub_in   = 2'd0;
                           count_in = '0;
                        end
                     end
                     PH_SYNC2: begin
                        if (rx_byte == SYNC_B) begin
                           phase_in = PH_LENGTH;
                           sub_in   = 2'd0;
                        end else begin
                           phase_in = PH_IDLE;
                           sub_in   = 2'd0;
                           count_in = '0;
                        end
                     end
                     PH_LENGTH: begin
                        if (sub_plus == PAIR) begin
                           phase_in = PH_HEAD;
                           sub_in   = 2'd0;
                        end else begin
                           sub_in = sub_plus;
                        end
                     end
                     PH_HEAD: begin
                        if (rx_byte != DELIM) begin
                           phase_in = PH_IDLE;
                           sub_in   = 2'd0;
                           count_in = '0;
                        end else if (sub_plus == PAIR) begin
                           phase_in = PH_DATA;
                           sub_in   = 2'd0;
                        end else begin
                           sub_in = sub_plus;
                        end
                     end
                     PH_DATA: begin
                        if (rx_byte == DELIM) begin
                           phase_in = PH_END;
                        end
                     end
                     PH_END: begin
                        if (rx_byte == DELIM) begin
                           phase_in = PH_HOLD;
                           ready    = 1'b1;
                        end else begin
                           phase_in = PH_IDLE;
                           sub_in   = 2'd0;
                           count_in = '0;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        sub_in   = 2'd0;
                        count_in = '0;
                     end
                  endcase
                  // buffer full: drop the frame and start over
                  if (count_plus >= (AW+1)'(BUFFER_DEPTH)) begin
                     phase_in = PH_IDLE;
                     sub_in   = 2'd0;
                     count_in = '0;
                     ready    = 1'b0;
                     abort    = 1'b1;
                  end
               end
            end
            OP_RELEASE: begin
               phase_in = PH_IDLE;
               sub_in   = 2'd0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.phase   = 3'(phase_in);
      result.ready   = ready;
      result.length  = 10'(count_in);
      result.aborted = abort;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sub_ff   <= 2'd0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         sub_ff   <= sub_in;
         count_ff <= count_in;
      end
   end

   `SDFR_ASSERT(a_count_below_depth, (32'(count_ff) < BUFFER_DEPTH), "stored count reached depth")
   `SDFR_ASSERT_IMP(a_no_write_in_hold, (phase_ff == PH_HOLD), !wr_en, "store written while holding")
   `SDFR_ASSERT_NXT(a_ready_enters_hold, ready, (phase_ff == PH_HOLD), "ready without hold")

endmodule

>>> rtl/sync_delimited_frame_receiver.sv
// An accepted item's result passes through the store read stage, then the output register.
// Throughput: one item per cycle while rsp does not stall; the store takes at most one write or one read per item.
// The input stalls only when both the read stage and the output register are full and rsp stalls.
// Reset (synchronous, active high) empties the pipeline and returns the parser to idle, count zero.
// Store contents are not cleared by reset; entries are defined once a received byte writes them.
`include "assert_macros.svh"

module sync_delimited_frame_receiver #(
   parameter int BUFFER_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_rx_byte,
   input  logic [9:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_parser_state,
   output logic       rsp_frame_ready,
   output logic [9:0] rsp_frame_length,
   output logic [7:0] rsp_read_data,
   output logic       rsp_aborted
);

   import sdfr_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);

   logic          accept;
   logic          s2_take;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic          rd_ok;
   logic [7:0]    rd_data;
   result_type    result;

   logic          s1_valid_ff, s1_valid_in;
   result_type    s1_res_ff, s1_res_in;
   logic          s1_rdok_ff, s1_rdok_in;
   logic          s2_valid_ff, s2_valid_in;
   result_type    s2_res_ff, s2_res_in;
   logic [7:0]    s2_rdata_ff, s2_rdata_in;

   // handshake
   assign s2_take   = !s2_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s2_take;
   assign accept    = req_valid && !req_stall;

   // reads of out-of-range positions return zero data
   assign rd_ok = (req_operation == OP_READ) && (32'(req_read_index) < BUFFER_DEPTH);
   assign rd_en = accept && (req_operation == OP_READ);

   sdfr_parser #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .operation(req_operation),
      .rx_byte  (req_rx_byte),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .result   (result)
   );

   sdfr_store #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(AW'(req_read_index)),
      .rd_data(rd_data)
   );

   // pipeline next values
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_res_in   = s1_res_ff;
      s1_rdok_in  = s1_rdok_ff;
      s2_valid_in = s2_valid_ff;
      s2_res_in   = s2_res_ff;
      s2_rdata_in = s2_rdata_ff;
      if (s2_take) begin
         s2_valid_in = s1_valid_ff;
         s2_res_in   = s1_res_ff;
         s2_rdata_in = s1_rdok_ff ? rd_data : 8'd0;
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_res_in   = result;
         s1_rdok_in  = rd_ok;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      s1_res_ff   <= s1_res_in;
      s1_rdok_ff  <= s1_rdok_in;
      s2_res_ff   <= s2_res_in;
      s2_rdata_ff <= s2_rdata_in;
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_parser_state = s2_res_ff.phase;
   assign rsp_frame_ready  = s2_res_ff.ready;
   assign rsp_frame_length = s2_res_ff.length;
   assign rsp_read_data    = s2_rdata_ff;
   assign rsp_aborted      = s2_res_ff.aborted;

   `SDFR_ASSERT_IMP(a_ready_in_hold, (rsp_valid && rsp_frame_ready),
                    (rsp_parser_state == PHASE_HOLD), "ready outside hold")
   `SDFR_ASSERT_IMP(a_abort_restarts, (rsp_valid && rsp_aborted),
                    (!rsp_frame_ready && rsp_frame_length == 10'd0
                     && rsp_parser_state == PHASE_IDLE), "abort without restart")
   `SDFR_ASSERT_IMP(a_stall_when_full, req_stall,
                    (s1_valid_ff && s2_valid_ff && rsp_stall), "input stalled with room")

endmodule
